[hw/rtl/strmq_pkg.sv]
// ----------------------------------------------------------------------------
// strmq_pkg
// Shared types and defaults for the sparse table range min/max engine.
// ----------------------------------------------------------------------------
package strmq_pkg;

  localparam int unsigned MaxLenDef     = 1024;
  localparam int unsigned ValueWidthDef = 32;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_BUILD  = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_NOT_BUILT = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // register index of the mode register
  localparam logic [1:0] RegModeSel = 2'd0;

  typedef struct packed {
    logic max_sel;
    logic mode_wr;
  } cfg_t;

endpackage

[hw/rtl/strmq_ram.sv]
// ----------------------------------------------------------------------------
// strmq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module strmq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/strmq_cfg.sv]
// ----------------------------------------------------------------------------
// strmq_cfg
// APB-style configuration register: mode select for minimum or maximum.
// ----------------------------------------------------------------------------
module strmq_cfg import strmq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic mode_q, mode_d;
  logic wr;
  logic [1:0] reg_idx;

  // word index of the addressed register
  assign reg_idx = paddr >> 2;
  assign wr      = psel & penable & pwrite & (reg_idx == RegModeSel);

  always_comb begin
    mode_d = mode_q;
    if (wr) begin
      mode_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  assign pready        = 1'b1;
  assign prdata        = {31'd0, mode_q};
  assign cfg_o.max_sel = mode_q;
  assign cfg_o.mode_wr = wr;

endmodule

[hw/rtl/strmq_seq.sv]
// ----------------------------------------------------------------------------
// strmq_seq
// Request sequencer: appends, table build sweep, two-read queries, clear.
// ----------------------------------------------------------------------------
module strmq_seq import strmq_pkg::*; #(
  parameter int unsigned MaxLen     = MaxLenDef,
  parameter int unsigned ValueWidth = ValueWidthDef,
  parameter int unsigned IdxW       = $clog2(MaxLen),
  parameter int unsigned Levels     = IdxW + 1,
  parameter int unsigned LvlW       = $clog2(Levels),
  parameter int unsigned AddrW      = LvlW + IdxW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [1:0]                   action_i,
  input  logic signed [ValueWidth-1:0] value_i,
  input  logic [IdxW-1:0]              from_index_i,
  input  logic [IdxW-1:0]              to_index_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic signed [ValueWidth-1:0] result_value_o,
  output logic [1:0]                   status_o,
  input  cfg_t                         cfg_i,
  output logic                         ram_we_o,
  output logic [AddrW-1:0]             ram_waddr_o,
  output logic [ValueWidth-1:0]        ram_wdata_o,
  output logic                         ram_re_o,
  output logic [AddrW-1:0]             ram_raddr_o,
  input  logic [ValueWidth-1:0]        ram_rdata_i
);

  localparam int unsigned CntW = IdxW + 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_BLVL = 8'b0000_0010,
    S_BRDA = 8'b0000_0100,
    S_BRDB = 8'b0000_1000,
    S_BWR  = 8'b0001_0000,
    S_QRDA = 8'b0010_0000,
    S_QRDB = 8'b0100_0000,
    S_QCMP = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic built_q, built_d;
  logic [LvlW:0] lvl_q, lvl_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] from_q, from_d;
  logic [IdxW-1:0] second_q, second_d;
  logic signed [ValueWidth-1:0] a_q, a_d;
  logic done_q, done_d;
  logic signed [ValueWidth-1:0] res_q, res_d;
  logic [1:0] stat_q, stat_d;

  logic accept;
  logic [LvlW-1:0] lvl_lo, lvl_below;
  logic [CntW:0] span, half, next_end;
  logic [IdxW-1:0] idx_b;
  logic [CntW-1:0] qlen, qspan, qsecond;
  logic [LvlW-1:0] qk;
  logic signed [ValueWidth-1:0] picked;

  function automatic logic signed [ValueWidth-1:0] pick(
    input logic                         max_mode,
    input logic signed [ValueWidth-1:0] a,
    input logic signed [ValueWidth-1:0] b
  );
    logic a_wins;
    a_wins = max_mode ? (a > b) : (a < b);
    return a_wins ? a : b;
  endfunction

  assign accept    = start_i & ~busy_o;
  assign lvl_lo    = lvl_q[LvlW-1:0];
  assign lvl_below = lvl_lo - LvlW'(1);
  assign span      = (CntW+1)'(1) << lvl_q;
  assign half      = span >> 1;
  assign idx_b     = idx_q + half[IdxW-1:0];
  assign next_end  = (CntW+1)'(idx_q) + (CntW+1)'(1) + span;
  assign picked    = pick(cfg_i.max_sel, a_q, $signed(ram_rdata_i));

  // level of a query: highest set bit of the range length
  assign qlen = CntW'(to_index_i) - CntW'(from_index_i) + CntW'(1);
  always_comb begin
    qk = '0;
    for (int j = 0; j < CntW; j++) begin
      if (qlen[j]) begin
        qk = LvlW'(j);
      end
    end
  end
  assign qspan   = CntW'(1) << qk;
  assign qsecond = CntW'(to_index_i) + CntW'(1) - qspan;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    built_d     = built_q;
    lvl_d       = lvl_q;
    idx_d       = idx_q;
    from_d      = from_q;
    second_d    = second_q;
    a_d         = a_q;
    done_d      = 1'b0;
    res_d       = res_q;
    stat_d      = stat_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = {lvl_lo, idx_q};
    ram_wdata_o = picked;
    ram_re_o    = 1'b0;
    ram_raddr_o = {lvl_below, idx_q};

    if (cfg_i.mode_wr) begin
      built_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          case (action_e'(action_i))
            ACT_APPEND: begin
              done_d = 1'b1;
              if (count_q == CntW'(MaxLen)) begin
                stat_d = ST_FULL;
              end else begin
                stat_d      = ST_OK;
                ram_we_o    = 1'b1;
                ram_waddr_o = {LvlW'(0), count_q[IdxW-1:0]};
                ram_wdata_o = value_i;
                count_d     = count_q + CntW'(1);
                built_d     = 1'b0;
              end
            end
            ACT_BUILD: begin
              lvl_d   = (LvlW+1)'(1);
              state_d = S_BLVL;
            end
            ACT_QUERY: begin
              done_d = 1'b1;
              if (!built_q) begin
                stat_d = ST_NOT_BUILT;
              end else if (from_index_i > to_index_i
                           || CntW'(to_index_i) >= count_q) begin
                stat_d = ST_BAD_RANGE;
              end else begin
                done_d   = 1'b0;
                lvl_d    = (LvlW+1)'(qk);
                from_d   = from_index_i;
                second_d = qsecond[IdxW-1:0];
                state_d  = S_QRDA;
              end
            end
            ACT_CLEAR: begin
              done_d  = 1'b1;
              stat_d  = ST_OK;
              count_d = '0;
              built_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_BLVL: begin
        if (lvl_q < (LvlW+1)'(Levels) && span <= (CntW+1)'(count_q)) begin
          idx_d   = '0;
          state_d = S_BRDA;
        end else begin
          built_d = 1'b1;
          done_d  = 1'b1;
          stat_d  = ST_OK;
          state_d = S_IDLE;
        end
      end
      S_BRDA: begin
        ram_re_o = 1'b1;
        state_d  = S_BRDB;
      end
      S_BRDB: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = {lvl_below, idx_b};
        a_d         = $signed(ram_rdata_i);
        state_d     = S_BWR;
      end
      S_BWR: begin
        ram_we_o = 1'b1;
        if (next_end <= (CntW+1)'(count_q)) begin
          idx_d   = idx_q + IdxW'(1);
          state_d = S_BRDA;
        end else begin
          lvl_d   = lvl_q + (LvlW+1)'(1);
          state_d = S_BLVL;
        end
      end
      S_QRDA: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = {lvl_lo, from_q};
        state_d     = S_QRDB;
      end
      S_QRDB: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = {lvl_lo, second_q};
        a_d         = $signed(ram_rdata_i);
        state_d     = S_QCMP;
      end
      S_QCMP: begin
        done_d  = 1'b1;
        stat_d  = ST_OK;
        res_d   = picked;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      built_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      built_q <= built_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q    <= lvl_d;
    idx_q    <= idx_d;
    from_q   <= from_d;
    second_q <= second_d;
    a_q      <= a_d;
    res_q    <= res_d;
    stat_q   <= stat_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign status_o       = stat_q;

endmodule

[hw/rtl/sparse_table_range_min_max_top.sv]
// ----------------------------------------------------------------------------
// sparse_table_range_min_max_top
// Sparse table range minimum/maximum engine with APB mode register.
// Append, clear and rejected requests: result strobe in the cycle after start.
// Query: two reads from the one table RAM port (QRDA, QRDB), then compare in QCMP.
// Build: per level a BLVL check, then per entry two reads (BRDA, BRDB) and a write (BWR).
// Reset clears count, built flag and mode; the table RAM is not cleared.
// ----------------------------------------------------------------------------
module sparse_table_range_min_max_top import strmq_pkg::*; #(
  parameter int unsigned MaxLen     = MaxLenDef,
  parameter int unsigned ValueWidth = ValueWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  output logic                         done_o,
  input  logic [1:0]                   action_i,
  input  logic signed [ValueWidth-1:0] value_i,
  input  logic [$clog2(MaxLen)-1:0]    from_index_i,
  input  logic [$clog2(MaxLen)-1:0]    to_index_i,
  output logic signed [ValueWidth-1:0] result_value_o,
  output logic [1:0]                   status_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [1:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned IdxW   = $clog2(MaxLen);
  localparam int unsigned Levels = IdxW + 1;
  localparam int unsigned LvlW   = $clog2(Levels);
  localparam int unsigned AddrW  = LvlW + IdxW;
  localparam int unsigned Depth  = Levels << IdxW;

  cfg_t cfg;
  logic ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [ValueWidth-1:0] ram_wdata, ram_rdata;

  strmq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  strmq_ram #(
    .Width (ValueWidth),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  strmq_seq #(
    .MaxLen     (MaxLen),
    .ValueWidth (ValueWidth)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .action_i       (action_i),
    .value_i        (value_i),
    .from_index_i   (from_index_i),
    .to_index_i     (to_index_i),
    .busy_o         (busy),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .cfg_i          (cfg),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

endmodule
